// ===== design/nvsd_pkg.sv =====
// Shared types, constants and helpers for the nearest view select and derotate core.
// Used by nvsd_table, nvsd_mac and the top level; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package nvsd_pkg;

    localparam int NUM_VIEWS_DEF = 16;
    localparam int CFG_W         = 5;
    localparam int DATA_W        = 16;
    localparam int PROD_W        = 2 * DATA_W;
    localparam int ACC_W         = PROD_W + 2;
    localparam int FRAC_BITS     = 14;
    localparam int Q_W           = ACC_W - FRAC_BITS;

    localparam logic [CFG_W-1:0] NUM_VIEWS_RST = CFG_W'(1);
    localparam logic [ACC_W-1:0] ROUND_HALF    = ACC_W'(1 << (FRAC_BITS - 1));

    localparam logic signed [Q_W-1:0] Q_MAX = Q_W'(32767);
    localparam logic signed [Q_W-1:0] Q_MIN = -Q_W'(32768);

    // Register slot number, taken from paddr above the byte offset
    localparam logic REG_NUM_VIEWS = 1'b0;

    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DOT,
        ST_CMP,
        ST_QUAT,
        ST_OUT
    } state_t;

    // One table entry: view direction plus z-axis rotation
    typedef struct packed {
        logic signed [DATA_W-1:0] vx;
        logic signed [DATA_W-1:0] vy;
        logic signed [DATA_W-1:0] vz;
        logic signed [DATA_W-1:0] rw;
        logic signed [DATA_W-1:0] rz;
    } entry_t;

    typedef struct packed {
        logic en;
        logic clr;
        logic rnd;
        logic neg;
    } mac_ctrl_t;

    // Floor-shift the Q5.28 sum to Q1.14 and clamp to 16 bits
    function automatic logic signed [DATA_W-1:0] sat_q14(input logic signed [ACC_W-1:0] v);
        logic signed [Q_W-1:0] q;
        logic signed [DATA_W-1:0] r;
        begin
            q = v[ACC_W-1:FRAC_BITS];
            if (q > Q_MAX)
            begin
                r = Q_MAX[DATA_W-1:0];
            end
            else if (q < Q_MIN)
            begin
                r = Q_MIN[DATA_W-1:0];
            end
            else
            begin
                r = q[DATA_W-1:0];
            end
            return r;
        end
    endfunction

endpackage

`default_nettype wire

// ===== design/nvsd_table.sv =====
// View and rotation table: one write port, one registered read port.
// Depends on nvsd_pkg for the entry type.
`timescale 1ns / 1ps
`default_nettype none

module nvsd_table #(
    parameter int NUM_VIEWS = nvsd_pkg::NUM_VIEWS_DEF,
    parameter int IDX_W     = 4
) (
    input  wire                  clk,
    input  wire                  we,
    input  wire [IDX_W-1:0]      waddr,
    input  nvsd_pkg::entry_t     wdata,
    input  wire [IDX_W-1:0]      raddr,
    output nvsd_pkg::entry_t     rdata
);
    import nvsd_pkg::*;

    entry_t mem [NUM_VIEWS];
    entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== design/nvsd_mac.sv =====
// Shared 16x16 signed multiply-accumulate unit used for dot products and
// the quaternion product. Depends on nvsd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module nvsd_mac (
    input  wire                                   clk,
    input  nvsd_pkg::mac_ctrl_t                   ctrl,
    input  wire signed [nvsd_pkg::DATA_W-1:0]     op_a,
    input  wire signed [nvsd_pkg::DATA_W-1:0]     op_b,
    output logic signed [nvsd_pkg::ACC_W-1:0]     acc
);
    import nvsd_pkg::*;

    logic signed [PROD_W-1:0] prod;
    logic signed [ACC_W-1:0]  prod_ext;
    logic signed [ACC_W-1:0]  base;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;

    always_comb
    begin
        prod     = op_a * op_b;
        prod_ext = {{(ACC_W - PROD_W){prod[PROD_W-1]}}, prod};
        if (ctrl.clr)
        begin
            base = ctrl.rnd ? ROUND_HALF : '0;
        end
        else
        begin
            base = acc_reg;
        end
        acc_next = ctrl.neg ? (base - prod_ext) : (base + prod_ext);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.en)
        begin
            acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule

`default_nettype wire

// ===== design/nearest_view_select_and_derotate_core.sv =====
// Nearest view select and derotate core: sequencer, config register, table and MAC.
// A load writes its table entry on the start transfer. A query runs 3 MAC steps and
// one compare for each of the count entries searched, then 8 MAC steps for the
// quaternion product and one state to store the last component; done then goes high.
// busy drops with done, so queries do not overlap; the receiver cannot stall.
// rst_n clears control state and sets num_views to 1; the table is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module nearest_view_select_and_derotate_core #(
    parameter int NUM_VIEWS = nvsd_pkg::NUM_VIEWS_DEF
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 start,
    output logic                                busy,
    input  wire                                 func,
    input  wire [3:0]                           entry_index,
    input  wire signed [nvsd_pkg::DATA_W-1:0]   vec_x,
    input  wire signed [nvsd_pkg::DATA_W-1:0]   vec_y,
    input  wire signed [nvsd_pkg::DATA_W-1:0]   vec_z,
    input  wire signed [nvsd_pkg::DATA_W-1:0]   rot_w,
    input  wire signed [nvsd_pkg::DATA_W-1:0]   rot_z,
    input  wire signed [nvsd_pkg::DATA_W-1:0]   ori_w,
    input  wire signed [nvsd_pkg::DATA_W-1:0]   ori_x,
    input  wire signed [nvsd_pkg::DATA_W-1:0]   ori_y,
    input  wire signed [nvsd_pkg::DATA_W-1:0]   ori_z,
    output logic                                done,
    output logic [3:0]                          best_index,
    output logic signed [nvsd_pkg::DATA_W-1:0]  res_w,
    output logic signed [nvsd_pkg::DATA_W-1:0]  res_x,
    output logic signed [nvsd_pkg::DATA_W-1:0]  res_y,
    output logic signed [nvsd_pkg::DATA_W-1:0]  res_z,
    input  wire                                 psel,
    input  wire                                 penable,
    input  wire                                 pwrite,
    input  wire [2:0]                           paddr,
    input  wire [31:0]                          pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);
    import nvsd_pkg::*;

    localparam int IDX_W = (NUM_VIEWS > 1) ? $clog2(NUM_VIEWS) : 1;
    localparam int CNT_W = $clog2(NUM_VIEWS + 1);
    localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam int BIX_W = (IDX_W > 4) ? IDX_W : 4;
    localparam logic [CMP_W-1:0] CNT_MAX = CMP_W'(NUM_VIEWS);

    // Config register
    logic [CFG_W-1:0] num_views_reg;
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_NUM_VIEWS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_views_reg <= NUM_VIEWS_RST;
        end
        else if (cfg_wr)
        begin
            num_views_reg <= pwdata[CFG_W-1:0];
        end
    end

    always_comb
    begin
        if (paddr[2] == REG_NUM_VIEWS)
        begin
            prdata = {{(32 - CFG_W){1'b0}}, num_views_reg};
        end
        else
        begin
            prdata = '0;
        end
    end

    // Last index searched: zero count searches entry 0, clamp at table depth
    logic [CMP_W-1:0] nv_ext;
    logic [CMP_W-1:0] cnt;
    logic [IDX_W-1:0] last_idx;

    always_comb
    begin
        nv_ext = CMP_W'(num_views_reg);
        if (nv_ext == '0)
        begin
            cnt = CMP_W'(1);
        end
        else if (nv_ext > CNT_MAX)
        begin
            cnt = CNT_MAX;
        end
        else
        begin
            cnt = nv_ext;
        end
        last_idx = IDX_W'(cnt - CMP_W'(1));
    end

    // Sequencer state
    state_t                   state_reg, state_next;
    logic [IDX_W-1:0]         idx_reg, idx_next;
    logic [2:0]               step_reg, step_next;
    logic [IDX_W-1:0]         best_reg, best_next;
    logic signed [ACC_W-1:0]  best_dp_reg, best_dp_next;
    logic                     done_reg, done_next;
    logic signed [DATA_W-1:0] look_reg [3];
    logic signed [DATA_W-1:0] ori_reg [4];
    logic signed [DATA_W-1:0] res_reg [4];
    logic                     res_we;
    logic [1:0]               res_sel;

    logic                     accept;
    logic                     load_we;
    logic [CMP_W-1:0]         entry_ext;

    entry_t                   wentry;
    entry_t                   rentry;
    logic [IDX_W-1:0]         raddr;

    mac_ctrl_t                mac_ctrl;
    logic signed [DATA_W-1:0] mac_a;
    logic signed [DATA_W-1:0] mac_b;
    logic signed [ACC_W-1:0]  acc;
    logic                     take;
    logic [1:0]               comp;

    assign busy      = (state_reg != ST_IDLE);
    assign accept    = start && !busy;
    assign entry_ext = CMP_W'(entry_index);
    assign load_we   = accept && (func == FUNC_LOAD) && (entry_ext < CNT_MAX);

    assign wentry.vx = vec_x;
    assign wentry.vy = vec_y;
    assign wentry.vz = vec_z;
    assign wentry.rw = rot_w;
    assign wentry.rz = rot_z;

    nvsd_table #(
        .NUM_VIEWS (NUM_VIEWS),
        .IDX_W     (IDX_W)
    ) u_table (
        .clk   (clk),
        .we    (load_we),
        .waddr (IDX_W'(entry_index)),
        .wdata (wentry),
        .raddr (raddr),
        .rdata (rentry)
    );

    nvsd_mac u_mac (
        .clk  (clk),
        .ctrl (mac_ctrl),
        .op_a (mac_a),
        .op_b (mac_b),
        .acc  (acc)
    );

    assign comp = step_reg[2:1];
    assign take = (idx_reg == '0) || (acc > best_dp_reg);

    always_comb
    begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        step_next    = step_reg;
        best_next    = best_reg;
        best_dp_next = best_dp_reg;
        done_next    = 1'b0;
        raddr        = '0;
        mac_ctrl     = '0;
        mac_a        = '0;
        mac_b        = '0;
        res_we       = 1'b0;
        res_sel      = 2'd0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (func == FUNC_QUERY))
                begin
                    idx_next   = '0;
                    step_next  = '0;
                    state_next = ST_DOT;
                end
            end

            ST_DOT:
            begin
                raddr        = idx_reg;
                mac_ctrl.en  = 1'b1;
                mac_ctrl.clr = (step_reg == 3'd0);
                case (step_reg[1:0])
                    2'd0:
                    begin
                        mac_a = look_reg[0];
                        mac_b = rentry.vx;
                    end
                    2'd1:
                    begin
                        mac_a = look_reg[1];
                        mac_b = rentry.vy;
                    end
                    default:
                    begin
                        mac_a = look_reg[2];
                        mac_b = rentry.vz;
                    end
                endcase
                if (step_reg == 3'd2)
                begin
                    step_next  = '0;
                    state_next = ST_CMP;
                end
                else
                begin
                    step_next = step_reg + 3'd1;
                end
            end

            ST_CMP:
            begin
                if (take)
                begin
                    best_next    = idx_reg;
                    best_dp_next = acc;
                end
                if (idx_reg == last_idx)
                begin
                    // fetch the winner's rotation for the product
                    raddr      = best_next;
                    state_next = ST_QUAT;
                end
                else
                begin
                    idx_next   = idx_reg + IDX_W'(1);
                    raddr      = idx_reg + IDX_W'(1);
                    state_next = ST_DOT;
                end
            end

            ST_QUAT:
            begin
                raddr        = best_reg;
                mac_ctrl.en  = 1'b1;
                mac_ctrl.clr = !step_reg[0];
                mac_ctrl.rnd = !step_reg[0];
                mac_ctrl.neg = step_reg[0] && !comp[1];
                mac_a        = step_reg[0] ? rentry.rz : rentry.rw;
                case (step_reg)
                    3'd0:    mac_b = ori_reg[0];
                    3'd1:    mac_b = ori_reg[3];
                    3'd2:    mac_b = ori_reg[1];
                    3'd3:    mac_b = ori_reg[2];
                    3'd4:    mac_b = ori_reg[2];
                    3'd5:    mac_b = ori_reg[1];
                    3'd6:    mac_b = ori_reg[3];
                    default: mac_b = ori_reg[0];
                endcase
                // store the component finished in the previous cycle
                if (!step_reg[0] && (step_reg != 3'd0))
                begin
                    res_we  = 1'b1;
                    res_sel = comp - 2'd1;
                end
                if (step_reg == 3'd7)
                begin
                    step_next  = '0;
                    state_next = ST_OUT;
                end
                else
                begin
                    step_next = step_reg + 3'd1;
                end
            end

            ST_OUT:
            begin
                res_we     = 1'b1;
                res_sel    = 2'd3;
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
            step_reg  <= '0;
            best_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            step_reg  <= step_next;
            best_reg  <= best_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_dp_reg <= best_dp_next;
        if (accept && (func == FUNC_QUERY))
        begin
            look_reg[0] <= vec_x;
            look_reg[1] <= vec_y;
            look_reg[2] <= vec_z;
            ori_reg[0]  <= ori_w;
            ori_reg[1]  <= ori_x;
            ori_reg[2]  <= ori_y;
            ori_reg[3]  <= ori_z;
        end
        if (res_we)
        begin
            res_reg[res_sel] <= sat_q14(acc);
        end
    end

    logic [BIX_W-1:0] best_ext;

    assign best_ext   = BIX_W'(best_reg);
    assign done       = done_reg;
    assign best_index = best_ext[3:0];
    assign res_w      = res_reg[0];
    assign res_x      = res_reg[1];
    assign res_y      = res_reg[2];
    assign res_z      = res_reg[3];

endmodule

`default_nettype wire
